[sv/rpre_pkg.sv]
// ----------------------------------------------------------------------------
// rpre_pkg
// Shared constants and types for the parity rebuild and extract unit.
// ----------------------------------------------------------------------------
package rpre_pkg;

    // Default array limits
    localparam int MAX_DISKS_DEF       = 8;
    localparam int MAX_STRIPE_BITS_DEF = 32;

    // Field widths
    localparam int DISK_W   = 8;
    localparam int NIBBLE_W = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    // Configuration register widths
    localparam int ND_W = 4;
    localparam int SB_W = 6;
    localparam int BC_W = 12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NUM_DISKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STRIPE_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ODD_PARITY  = 2'd3;

    // Commands from the sequencer to the nibble packer
    typedef struct packed {
        logic push;      // shift one data bit in
        logic push_bit;  // the data bit
        logic pad;       // close a partial nibble with zero padding
        logic flush;     // move the held nibble out as the final result
        logic set_end;   // flushed nibble closes the disk set
        logic err;       // sticky error of the current set
    } t_pack_cmd;

    // Status from the nibble packer to the sequencer
    typedef struct packed {
        logic take;          // a push is taken this cycle
        logic can_complete;  // a finished nibble can be held this cycle
        logic out_free;      // output register can load this cycle
        logic pend_valid;    // a finished nibble is held
        logic fill_zero;     // no partial nibble
    } t_pack_stat;

endpackage

[sv/rpre_ifs.sv]
// ----------------------------------------------------------------------------
// rpre interfaces
// Column input, nibble result and configuration write channels.
// ----------------------------------------------------------------------------
interface rpre_item_if;
    logic       valid;
    logic       ready;
    logic [7:0] disk_bits;
    logic [7:0] lost_mask;

    modport source (output valid, output disk_bits, output lost_mask, input ready);
    modport sink   (input valid, input disk_bits, input lost_mask, output ready);
endinterface

interface rpre_result_if;
    logic       valid;
    logic       ready;
    logic [3:0] nibble;
    logic       set_error;
    logic       set_end;
    logic       last;

    modport source (output valid, output nibble, output set_error, output set_end,
                    output last, input ready);
    modport sink   (input valid, input nibble, input set_error, input set_end,
                    input last, output ready);
endinterface

interface rpre_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/rpre_col_check.sv]
// ----------------------------------------------------------------------------
// rpre_col_check
// Parity check and single-bit rebuild of one bit column.
// ----------------------------------------------------------------------------
module rpre_col_check #(
    parameter int MAX_DISKS = 8
) (
    input  logic [rpre_pkg::DISK_W-1:0] i_disk_bits,
    input  logic [rpre_pkg::DISK_W-1:0] i_lost_mask,
    input  logic [rpre_pkg::ND_W-1:0]   i_num_disks,
    input  logic                        i_odd_parity,
    output logic [MAX_DISKS-1:0]        o_col_bits,
    output logic                        o_fail
);
    import rpre_pkg::*;

    logic [DISK_W-1:0] dmask;
    logic [DISK_W-1:0] lost;
    logic [DISK_W-1:0] good;
    logic [DISK_W-1:0] fixed;
    logic              par_k;
    logic              none_lost;
    logic              multi_lost;

    // Mask off disks beyond the active count
    always_comb begin
        for (int i = 0; i < DISK_W; i++) begin
            dmask[i] = (ND_W'(i) < i_num_disks);
        end
    end

    assign lost       = i_lost_mask & dmask;
    assign good       = i_disk_bits & dmask & ~lost;
    assign par_k      = ^good;
    assign none_lost  = (lost == '0);
    assign multi_lost = !none_lost && ((lost & (lost - DISK_W'(1))) != '0);

    // Rebuild a single lost bit from the parity of the rest
    assign fixed = (!none_lost && !multi_lost && (par_k ^ i_odd_parity)) ? (good | lost) : good;

    // Flag a mismatch with nothing lost, or more than one lost bit
    assign o_fail     = (none_lost && (par_k != i_odd_parity)) || multi_lost;
    assign o_col_bits = fixed[MAX_DISKS-1:0];

endmodule

[sv/rpre_col_mem.sv]
// ----------------------------------------------------------------------------
// rpre_col_mem
// Block column buffer: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rpre_col_mem #(
    parameter int MAX_DISKS       = 8,
    parameter int MAX_STRIPE_BITS = 32,
    parameter int CW              = 5
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [CW-1:0]        i_wr_addr,
    input  logic [MAX_DISKS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [CW-1:0]        i_rd_addr,
    output logic [MAX_DISKS-1:0] o_rd_data
);
    logic [MAX_DISKS-1:0] mem [MAX_STRIPE_BITS];
    logic [MAX_DISKS-1:0] r_rd_data;

    // Write a column; the walk never reads in the cycle of a write
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read; hold data while stalled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/rpre_nib_pack.sv]
// ----------------------------------------------------------------------------
// rpre_nib_pack
// MSB-first nibble packer with a one-nibble hold stage and output register.
// ----------------------------------------------------------------------------
module rpre_nib_pack (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rpre_pkg::t_pack_cmd   i_cmd,
    output rpre_pkg::t_pack_stat  o_stat,
    rpre_result_if.source         o_result
);
    import rpre_pkg::*;

    logic [NIBBLE_W-1:0] r_acc;
    logic [1:0]          r_fill;
    logic                r_pend_v;
    logic [NIBBLE_W-1:0] r_pend_nib;
    logic                r_out_v;
    logic [NIBBLE_W-1:0] r_out_nib;
    logic                r_out_err;
    logic                r_out_end;
    logic                r_out_last;

    logic                out_free;
    logic                complete;
    logic [NIBBLE_W-1:0] pad_val;
    logic [NIBBLE_W-1:0] nib_new;
    logic                load_mid;

    assign out_free = !r_out_v || o_result.ready;

    // Zero-pad a partial nibble into the high bits
    always_comb begin
        case (r_fill)
            2'd1:    pad_val = {r_acc[0], 3'b000};
            2'd2:    pad_val = {r_acc[1:0], 2'b00};
            2'd3:    pad_val = {r_acc[2:0], 1'b0};
            default: pad_val = r_acc;
        endcase
    end

    assign complete = (i_cmd.push && (r_fill == 2'd3)) || i_cmd.pad;
    assign nib_new  = i_cmd.pad ? pad_val : {r_acc[2:0], i_cmd.push_bit};
    assign load_mid = complete && r_pend_v;

    // Shift bits in and hold each finished nibble
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_fill   <= '0;
            r_pend_v <= 1'b0;
        end else begin
            if (complete) begin
                r_acc      <= '0;
                r_fill     <= '0;
                r_pend_v   <= 1'b1;
                r_pend_nib <= nib_new;
            end else if (i_cmd.push) begin
                r_acc  <= {r_acc[2:0], i_cmd.push_bit};
                r_fill <= r_fill + 2'd1;
            end else if (i_cmd.flush) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    // Load the output register: a displaced nibble, or the final one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            if (load_mid || i_cmd.flush) begin
                r_out_v <= 1'b1;
            end else if (o_result.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_mid) begin
            r_out_nib  <= r_pend_nib;
            r_out_err  <= i_cmd.err;
            r_out_end  <= 1'b0;
            r_out_last <= 1'b0;
        end else if (i_cmd.flush) begin
            r_out_nib  <= r_pend_nib;
            r_out_err  <= i_cmd.err;
            r_out_end  <= i_cmd.set_end;
            r_out_last <= 1'b1;
        end
    end

    assign o_result.valid     = r_out_v;
    assign o_result.nibble    = r_out_nib;
    assign o_result.set_error = r_out_err;
    assign o_result.set_end   = r_out_end;
    assign o_result.last      = r_out_last;

    // Report what the packer can take this cycle
    assign o_stat.can_complete = !r_pend_v || out_free;
    assign o_stat.take         = (r_fill != 2'd3) || !r_pend_v || out_free;
    assign o_stat.out_free     = out_free;
    assign o_stat.pend_valid   = r_pend_v;
    assign o_stat.fill_zero    = (r_fill == 2'd0);

endmodule

[sv/raid_parity_rebuild_extract_unit.sv]
// The last column of a block starts a walk of the column buffer at one bit per
// cycle through its single read port while the packer takes bits; the walk
// can stall while the output is stalled. A finished nibble waits in a hold
// stage before it moves to the output register.
// Throughput: one column per cycle within a block, then the block walk.
// Reset clears control state and counters; the column buffer is not cleared.
// ----------------------------------------------------------------------------
// raid_parity_rebuild_extract_unit
// Parity check, single-bit rebuild and data extraction for a small disk array.
// ----------------------------------------------------------------------------
module raid_parity_rebuild_extract_unit #(
    parameter int MAX_DISKS       = rpre_pkg::MAX_DISKS_DEF,
    parameter int MAX_STRIPE_BITS = rpre_pkg::MAX_STRIPE_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    rpre_cfg_if.sink       i_cfg,
    rpre_item_if.sink      i_item,
    rpre_result_if.source  o_result
);
    import rpre_pkg::*;

    localparam int CW  = (MAX_STRIPE_BITS > 1) ? $clog2(MAX_STRIPE_BITS) : 1;
    localparam int DW  = $clog2(MAX_DISKS);
    localparam int DCW = $clog2(MAX_DISKS + 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FIN   = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    // Configuration registers
    logic [ND_W-1:0] r_num_disks;
    logic [SB_W-1:0] r_stripe_bits;
    logic [BC_W-1:0] r_block_count;
    logic            r_odd_parity;

    // Set position and walk state
    logic [1:0]     r_state;
    logic [CW-1:0]  r_col_idx;
    logic [BC_W-1:0] r_blk;
    logic [DW-1:0]  r_pd;
    logic           r_err;
    logic           r_a_act;
    logic [CW-1:0]  r_wcol;
    logic [DCW-1:0] r_disk;
    logic           r_b_valid;
    logic [DCW-1:0] r_b_disk;

    logic [ND_W-1:0]      nd;
    logic [SB_W-1:0]      ns;
    logic [BC_W-1:0]      nb;
    logic [MAX_DISKS-1:0] col_bits;
    logic                 col_fail;
    logic [MAX_DISKS-1:0] rd_data;
    logic                 accept;
    logic                 col_last;
    logic                 wcol_last;
    logic                 hold;
    logic                 rd_en;
    logic                 final_blk;
    logic [DCW-1:0]       disk_p1;
    logic [DCW-1:0]       disk_nx;
    logic [DCW-1:0]       start_disk;
    logic [ND_W-1:0]      pd_p1;
    t_pack_cmd            cmd;
    t_pack_stat           stat;

    // Saturate the configuration to its legal ranges
    assign nd = (r_num_disks < ND_W'(2)) ? ND_W'(2) :
                (r_num_disks > ND_W'(MAX_DISKS)) ? ND_W'(MAX_DISKS) : r_num_disks;
    assign ns = (r_stripe_bits == '0) ? SB_W'(1) :
                (r_stripe_bits > SB_W'(MAX_STRIPE_BITS)) ? SB_W'(MAX_STRIPE_BITS) : r_stripe_bits;
    assign nb = (r_block_count == '0) ? BC_W'(1) : r_block_count;

    // Accept register writes at any time
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_disks   <= ND_W'(2);
            r_stripe_bits <= SB_W'(1);
            r_block_count <= BC_W'(1);
            r_odd_parity  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_NUM_DISKS:   r_num_disks   <= i_cfg.data[ND_W-1:0];
                REG_STRIPE_BITS: r_stripe_bits <= i_cfg.data[SB_W-1:0];
                REG_BLOCK_COUNT: r_block_count <= i_cfg.data[BC_W-1:0];
                REG_ODD_PARITY:  r_odd_parity  <= i_cfg.data[0];
                default:         r_odd_parity  <= r_odd_parity;
            endcase
        end
    end

    // Column parity check and rebuild
    rpre_col_check #(
        .MAX_DISKS (MAX_DISKS)
    ) u_check (
        .i_disk_bits  (i_item.disk_bits),
        .i_lost_mask  (i_item.lost_mask),
        .i_num_disks  (nd),
        .i_odd_parity (r_odd_parity),
        .o_col_bits   (col_bits),
        .o_fail       (col_fail)
    );

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && (r_state == ST_IDLE);
    assign col_last     = (SB_W'(r_col_idx) + SB_W'(1)) >= ns;

    // Walk stage A issues reads, stage B pushes the returned bit
    assign hold      = r_b_valid && !stat.take;
    assign rd_en     = (r_state == ST_WALK) && r_a_act && !hold;
    assign wcol_last = (SB_W'(r_wcol) + SB_W'(1)) >= ns;
    assign disk_p1   = r_disk + DCW'(1);
    assign disk_nx   = (disk_p1 == DCW'(r_pd)) ? (r_disk + DCW'(2)) : disk_p1;
    assign start_disk = (r_pd == '0) ? DCW'(1) : DCW'(0);
    assign final_blk = ({1'b0, r_blk} + (BC_W+1)'(1)) >= {1'b0, nb};
    assign pd_p1     = ND_W'(r_pd) + ND_W'(1);

    rpre_col_mem #(
        .MAX_DISKS       (MAX_DISKS),
        .MAX_STRIPE_BITS (MAX_STRIPE_BITS),
        .CW              (CW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (accept),
        .i_wr_addr (r_col_idx),
        .i_wr_data (col_bits),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_wcol),
        .o_rd_data (rd_data)
    );

    // Drive the packer from the walk and the closing states
    always_comb begin
        cmd          = '0;
        cmd.err      = r_err;
        cmd.set_end  = final_blk;
        cmd.push_bit = rd_data[r_b_disk[DW-1:0]];
        case (r_state)
            ST_WALK: begin
                cmd.push = r_b_valid && stat.take;
            end
            ST_FIN: begin
                cmd.pad = final_blk && !stat.fill_zero && stat.can_complete;
            end
            ST_FLUSH: begin
                cmd.flush = stat.pend_valid && stat.out_free;
            end
            default: begin
                cmd.push = 1'b0;
            end
        endcase
    end

    rpre_nib_pack u_pack (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_result (o_result)
    );

    // Sequence columns, block walks and set boundaries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_col_idx <= '0;
            r_blk     <= '0;
            r_pd      <= '0;
            r_err     <= 1'b0;
            r_a_act   <= 1'b0;
            r_wcol    <= '0;
            r_disk    <= '0;
            r_b_valid <= 1'b0;
            r_b_disk  <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_err <= r_err | col_fail;
                        if (col_last) begin
                            r_col_idx <= '0;
                            r_a_act   <= 1'b1;
                            r_wcol    <= '0;
                            r_disk    <= start_disk;
                            r_b_valid <= 1'b0;
                            r_state   <= ST_WALK;
                        end else begin
                            r_col_idx <= r_col_idx + CW'(1);
                        end
                    end
                end
                ST_WALK: begin
                    if (!hold) begin
                        r_b_valid <= r_a_act;
                        r_b_disk  <= r_disk;
                        if (r_a_act) begin
                            if (wcol_last) begin
                                r_wcol <= '0;
                                r_disk <= disk_nx;
                                if (ND_W'(disk_nx) >= nd) begin
                                    r_a_act <= 1'b0;
                                end
                            end else begin
                                r_wcol <= r_wcol + CW'(1);
                            end
                        end
                    end
                    if (!r_a_act && !r_b_valid) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (!(final_blk && !stat.fill_zero) || stat.can_complete) begin
                        r_state <= ST_FLUSH;
                    end
                end
                ST_FLUSH: begin
                    if (!stat.pend_valid || stat.out_free) begin
                        r_state <= ST_IDLE;
                        if (final_blk) begin
                            r_blk <= '0;
                            r_pd  <= '0;
                            r_err <= 1'b0;
                        end else begin
                            r_blk <= r_blk + BC_W'(1);
                            r_pd  <= (pd_p1 >= nd) ? '0 : DW'(pd_p1);
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the parity rebuild and extract unit: streams bit
// columns through the input channel, predicts the nibble stream and compares
// every result transaction against the prediction.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpre_pkg::*;

    // Longest block walk plus margin, used to let the unit settle
    localparam int WALK_CYCLES = MAX_DISKS_DEF * MAX_STRIPE_BITS_DEF + 16;
    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic [DISK_W-1:0] disk_bits;
        logic [DISK_W-1:0] lost_mask;
    } t_column;

    typedef struct packed {
        logic [NIBBLE_W-1:0] nibble;
        logic                set_error;
        logic                set_end;
        logic                last;
    } t_nibble;

    logic i_clk;
    logic i_rst_n;

    rpre_item_if   item_ch ();
    rpre_result_if res_ch ();
    rpre_cfg_if    cfg_ch ();

    raid_parity_rebuild_extract_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg_ch),
        .i_item   (item_ch),
        .o_result (res_ch)
    );

    // Pending columns and expected nibbles
    t_column column_q[$];
    t_nibble nibble_q[$];

    // Shadow of the array configuration
    logic [ND_W-1:0] sh_num_disks;
    logic [SB_W-1:0] sh_stripe_bits;
    logic [BC_W-1:0] sh_block_count;
    logic            sh_odd_parity;

    // Shadow of the rebuild and packing state
    logic [DISK_W-1:0]   sh_store [MAX_STRIPE_BITS_DEF];
    logic [4:0]          sh_col;
    logic [BC_W-1:0]     sh_blk;
    logic [2:0]          sh_parity_disk;
    logic [NIBBLE_W-1:0] sh_acc;
    int                  sh_fill;
    logic                sh_err;

    // Idling controls
    bit src_gaps_on;
    bit sink_gaps_on;
    int src_gap;
    int sink_gap;
    int hold_req_cnt;
    int hold_ack_cnt;
    int hold_left;

    int fail_count;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    initial begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int eff_disks();
        if (sh_num_disks < 2) return 2;
        if (sh_num_disks > MAX_DISKS_DEF) return MAX_DISKS_DEF;
        return sh_num_disks;
    endfunction

    task automatic log_failure(input string msg);
        if (fail_count < 10) $display("FAIL @%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // Check and rebuild one column, then walk the block on its last column
    task automatic rebuild_column(input logic [DISK_W-1:0] dbits,
                                  input logic [DISK_W-1:0] lmask);
        int nd, ns, nb, nlost;
        logic [DISK_W-1:0] dmask, lost, bits;
        logic k;
        t_nibble blk_out[$];
        t_nibble n;
        nd = eff_disks();
        ns = (sh_stripe_bits < 1) ? 1 :
             (sh_stripe_bits > MAX_STRIPE_BITS_DEF ? MAX_STRIPE_BITS_DEF : sh_stripe_bits);
        nb = (sh_block_count < 1) ? 1 : sh_block_count;
        dmask = DISK_W'((1 << nd) - 1);
        lost = lmask & dmask;
        bits = dbits & dmask & ~lost;
        k = ^bits;
        nlost = $countones(lost);
        if (nlost == 0) begin
            if (k != sh_odd_parity) sh_err = 1'b1;
        end else if (nlost == 1) begin
            if (k ^ sh_odd_parity) bits = bits | lost;
        end else begin
            sh_err = 1'b1;
        end
        sh_store[sh_col] = bits;
        if (sh_col + 1 < ns) begin
            sh_col = 5'(sh_col + 1);
            return;
        end
        sh_col = '0;

        // Extract data bits disk by disk, skipping the parity disk
        for (int j = 0; j < nd; j++) begin
            if (j == sh_parity_disk) continue;
            for (int c = 0; c < ns; c++) begin
                sh_acc = {sh_acc[2:0], sh_store[c][j]};
                sh_fill++;
                if (sh_fill == 4) begin
                    n.nibble = sh_acc;
                    n.set_error = sh_err;
                    n.set_end = 1'b0;
                    n.last = 1'b0;
                    blk_out.push_back(n);
                    sh_acc = '0;
                    sh_fill = 0;
                end
            end
        end

        if (sh_blk + 1 >= nb) begin
            // Close the set: pad a partial nibble or mark the final one
            if (sh_fill != 0) begin
                n.nibble = NIBBLE_W'(sh_acc << (4 - sh_fill));
                n.set_error = sh_err;
                n.set_end = 1'b1;
                n.last = 1'b0;
                blk_out.push_back(n);
            end else if (blk_out.size() > 0) begin
                blk_out[blk_out.size() - 1].set_end = 1'b1;
            end
            sh_blk = '0;
            sh_parity_disk = '0;
            sh_acc = '0;
            sh_fill = 0;
            sh_err = 1'b0;
        end else begin
            sh_blk = BC_W'(sh_blk + 1);
            if (sh_parity_disk + 1 >= nd) sh_parity_disk = '0;
            else sh_parity_disk = 3'(sh_parity_disk + 1);
        end

        if (blk_out.size() > 0) blk_out[blk_out.size() - 1].last = 1'b1;
        foreach (blk_out[i]) nibble_q.push_back(blk_out[i]);
    endtask

    // Mostly consistent columns with at most one lost bit, some raw noise
    function automatic t_column make_column();
        t_column col;
        int nd, pd, ld;
        logic [DISK_W-1:0] dm;
        nd = eff_disks();
        col.disk_bits = DISK_W'($urandom);
        col.lost_mask = DISK_W'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            dm = DISK_W'((1 << nd) - 1);
            pd = $urandom_range(0, nd - 1);
            if ((^(col.disk_bits & dm)) != sh_odd_parity)
                col.disk_bits[pd] = ~col.disk_bits[pd];
            col.lost_mask = col.lost_mask & ~dm;
            if ($urandom_range(0, 2) == 0) begin
                ld = $urandom_range(0, nd - 1);
                col.lost_mask[ld] = 1'b1;
                col.disk_bits[ld] = 1'($urandom_range(0, 1));
            end
        end
        return col;
    endfunction

    // Write one register and update the shadow on acceptance
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        case (idx)
            REG_NUM_DISKS:   sh_num_disks   = val[ND_W-1:0];
            REG_STRIPE_BITS: sh_stripe_bits = val[SB_W-1:0];
            REG_BLOCK_COUNT: sh_block_count = val[BC_W-1:0];
            REG_ODD_PARITY:  sh_odd_parity  = val[0];
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_array(input int nd, input int ns, input int nb, input int odd);
        write_reg(REG_NUM_DISKS,   {8'($urandom), 4'(nd)});
        write_reg(REG_STRIPE_BITS, {6'($urandom), 6'(ns)});
        write_reg(REG_BLOCK_COUNT, 12'(nb));
        write_reg(REG_ODD_PARITY,  {11'($urandom), 1'(odd)});
    endtask

    // Wait until every column is in and every nibble is out, then settle
    task automatic drain();
        while (column_q.size() > 0 || item_ch.valid || nibble_q.size() > 0)
            @(posedge i_clk);
        repeat (WALK_CYCLES) @(posedge i_clk);
    endtask

    task automatic add_column(input logic [DISK_W-1:0] d, input logic [DISK_W-1:0] l);
        t_column col;
        col.disk_bits = d;
        col.lost_mask = l;
        column_q.push_back(col);
    endtask

    // Column driver
    always @(posedge i_clk) begin : drive_columns
        t_column nxt;
        if (!i_rst_n) begin
            item_ch.valid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (item_ch.valid && item_ch.ready)
                rebuild_column(item_ch.disk_bits, item_ch.lost_mask);
            if (!item_ch.valid || item_ch.ready) begin
                if (src_gap > 0) begin
                    item_ch.valid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (column_q.size() > 0) begin
                    nxt = column_q.pop_front();
                    item_ch.valid     <= 1'b1;
                    item_ch.disk_bits <= nxt.disk_bits;
                    item_ch.lost_mask <= nxt.lost_mask;
                    if (src_gaps_on) src_gap <= pick_gap();
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_ack_cnt <= 0;
            hold_left <= 0;
        end else if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor and ready generation
    always @(posedge i_clk) begin : watch_results
        t_nibble got, want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            sink_gap <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got.nibble    = res_ch.nibble;
                got.set_error = res_ch.set_error;
                got.set_end   = res_ch.set_end;
                got.last      = res_ch.last;
                if (nibble_q.size() == 0) begin
                    log_failure($sformatf("unexpected result nibble=%h err=%b end=%b last=%b",
                                          got.nibble, got.set_error, got.set_end, got.last));
                end else begin
                    want = nibble_q.pop_front();
                    if (got.nibble !== want.nibble || got.set_error !== want.set_error ||
                        got.set_end !== want.set_end || got.last !== want.last)
                        log_failure($sformatf(
                            "exp nibble=%h err=%b end=%b last=%b, got nibble=%h err=%b end=%b last=%b",
                            want.nibble, want.set_error, want.set_end, want.last,
                            got.nibble, got.set_error, got.set_end, got.last));
                end
            end
            if (hold_left != 0) begin
                res_ch.ready <= 1'b0;
            end else if (sink_gap > 0) begin
                res_ch.ready <= 1'b0;
                sink_gap <= sink_gap - 1;
            end else begin
                res_ch.ready <= 1'b1;
                if (sink_gaps_on) sink_gap <= pick_gap();
            end
        end
    end

    // Stimulus sequence
    initial begin
        int random_sent, n, r, nd, ns, nb;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        sh_num_disks = 4'd2;
        sh_stripe_bits = 6'd1;
        sh_block_count = 12'd1;
        sh_odd_parity = 1'b0;
        foreach (sh_store[i]) sh_store[i] = '0;
        sh_col = '0;
        sh_blk = '0;
        sh_parity_disk = '0;
        sh_acc = '0;
        sh_fill = 0;
        sh_err = 1'b0;
        src_gaps_on = 1'b1;
        sink_gaps_on = 1'b1;
        hold_req_cnt = 0;
        fail_count = 0;
        random_sent = 0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Warm-up: one full-width block writes every buffer entry
        write_array(8, 32, 1, 0);
        repeat (32) column_q.push_back(make_column());
        drain();

        // Even parity, one block per set: match, mask beyond the array, mismatch
        write_array(4, 4, 1, 0);
        add_column(8'h00, 8'h00);
        add_column(8'hFF, 8'h00);
        add_column(8'h01, 8'h00);
        add_column(8'hF0, 8'h00);
        // Rebuild to one, rebuild to zero, lost bits beyond the array, two lost
        add_column(8'h01, 8'h02);
        add_column(8'h07, 8'h04);
        add_column(8'h03, 8'hF0);
        add_column(8'h00, 8'h06);
        drain();

        // Odd parity over three disks, three blocks per set
        write_array(3, 2, 3, 1);
        add_column(8'h01, 8'h00);
        add_column(8'h07, 8'h00);
        add_column(8'h03, 8'h01);
        add_column(8'h00, 8'h02);
        add_column(8'h00, 8'h00);
        add_column(8'hFF, 8'hFF);
        drain();

        // Out-of-range registers saturate
        write_array(0, 0, 0, 0);
        add_column(8'h03, 8'h00);
        add_column(8'h01, 8'h02);
        drain();

        // Shrink disks and blocks mid-set: parity disk past the end skips none
        write_array(5, 1, 4, 0);
        add_column(8'h11, 8'h00);
        add_column(8'h0A, 8'h04);
        add_column(8'h1E, 8'h00);
        drain();
        write_reg(REG_NUM_DISKS, 12'd3);
        write_reg(REG_BLOCK_COUNT, 12'd2);
        add_column(8'h05, 8'h00);
        drain();

        // Shrink stripe mid-block: current column becomes the last
        write_array(4, 4, 1, 0);
        add_column(8'h0F, 8'h00);
        add_column(8'h06, 8'h00);
        drain();
        write_reg(REG_STRIPE_BITS, 12'd2);
        add_column(8'h09, 8'h00);
        drain();

        // Backpressure: receiver holds off while columns keep coming
        write_array(8, 2, 3, $urandom_range(0, 1));
        src_gaps_on = 1'b0;
        sink_gaps_on = 1'b0;
        repeat (60) column_q.push_back(make_column());
        hold_req_cnt++;
        random_sent += 60;
        drain();

        // Random phases with occasional register changes between them
        while (random_sent < RANDOM_ITEMS) begin
            src_gaps_on = ($urandom_range(0, 9) < 7);
            sink_gaps_on = ($urandom_range(0, 9) < 7);

            r = $urandom_range(0, 99);
            nd = (r < 85) ? $urandom_range(2, 8) :
                 ((r < 92) ? $urandom_range(0, 1) : $urandom_range(9, 15));
            r = $urandom_range(0, 99);
            ns = (r < 70) ? $urandom_range(1, 4) :
                 (r < 85) ? $urandom_range(5, 12) :
                 (r < 93) ? 32 :
                 (r < 96) ? 0 : $urandom_range(33, 63);
            r = $urandom_range(0, 99);
            nb = (r < 80) ? $urandom_range(1, 4) :
                 (r < 90) ? 0 :
                 (r < 95) ? 4095 : $urandom_range(5, 20);

            if ($urandom_range(0, 9) < 6) write_reg(REG_NUM_DISKS, {8'($urandom), 4'(nd)});
            if ($urandom_range(0, 9) < 6) write_reg(REG_STRIPE_BITS, {6'($urandom), 6'(ns)});
            if ($urandom_range(0, 9) < 6) write_reg(REG_BLOCK_COUNT, 12'(nb));
            if ($urandom_range(0, 9) < 6)
                write_reg(REG_ODD_PARITY, {11'($urandom), 1'($urandom_range(0, 1))});

            n = $urandom_range(4, 30);
            repeat (n) column_q.push_back(make_column());
            random_sent += n;
            drain();
        end

        if (fail_count == 0 && nibble_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
